// File: hdl/cpva_pkg.sv
// Shared constants for the convex polygon check and area block.
`default_nettype none

package cpva_pkg;

  // Result status codes; precedence runs short, concave, zero area, then valid
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CONCAVE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_AREA = 2'd3;

  // Shoelace accumulator wraps at this width; the reported magnitude saturates
  localparam int unsigned AREA_W       = 40;
  localparam int unsigned TWICE_AREA_W = 34;

  // Vertex count saturates here
  localparam int unsigned COUNT_W = 2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

endpackage

`default_nettype wire

// File: hdl/cpva_vertex_if.sv
// Vertex channel: one polygon vertex per transfer.
`default_nettype none

interface cpva_vertex_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         is_last;

  modport source (output valid, output vertex_x, output vertex_y, output is_last,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input is_last,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/cpva_result_if.sv
// Result channel: status and twice the area of one polygon per transfer.
`default_nettype none

interface cpva_result_if;
  logic                                valid;
  logic                                ready;
  logic [cpva_pkg::STATUS_W-1:0]       status;
  logic [cpva_pkg::TWICE_AREA_W-1:0]   twice_area;

  modport source (output valid, output status, output twice_area, input ready);
  modport sink   (input valid, input status, input twice_area, output ready);
endinterface

`default_nettype wire

// File: hdl/convex_polygon_validate_area.sv
// Top level of the convex polygon check and shoelace area block.
//
// Usage:
//   vertex_i carries one vertex per transfer (vertex_x, vertex_y, is_last).
//   A polygon is the run of vertices up to and including one with is_last set.
//   result_o carries one transfer per polygon: status (fewer than three
//   vertices, not convex, zero area, checked in that order, else valid) and
//   twice_area, the absolute shoelace sum saturated to 34 bits.
//   Throughput: one vertex per cycle, back to back, across polygon borders, while results are taken.
//   The figure is set by the single area accumulate and convexity update per
//   vertex in the back end; the ten products of a vertex run in parallel.
//   Result path of the last vertex: queue, product stage, cross stage,
//   accumulate stage, result register.
//   Reset: starts an empty polygon, drains queue and pipeline, no result.
//   Receiver stall: the result register holds, the back end freezes, and the
//   two-entry job queue absorbs vertices until full, then vertex_i.ready drops.
`default_nettype none

module convex_polygon_validate_area #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpva_vertex_if.sink   vertex_i,
  cpva_result_if.source result_o
);
  import cpva_pkg::*;

  // One job per accepted vertex: the coordinates the back end multiplies
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic                         last;
    logic signed [COORD_BITS-1:0] lat_x, lat_y, cur_x, cur_y, fst_x, fst_y;
    logic signed [COORD_BITS:0]   da1_x, da1_y, da2_x, da2_y;
    logic signed [COORD_BITS:0]   db2_x, db2_y, dc2_x, dc2_y;
  } job_t;

  logic front_valid, front_ready;
  logic back_valid, back_ready;
  job_t front_job, back_job;

  // Front end: classify the vertex against the polygon state, build the job
  cpva_front #(
    .COORD_BITS (COORD_BITS),
    .job_t      (job_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vertex_i.valid),
    .in_ready_o  (vertex_i.ready),
    .vertex_x_i  (vertex_i.vertex_x),
    .vertex_y_i  (vertex_i.vertex_y),
    .is_last_i   (vertex_i.is_last),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  // Queue: lets the front keep taking vertices while the back end stalls
  cpva_job_fifo #(
    .item_t (job_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_job)
  );

  // Back end: arithmetic pipeline and result register
  cpva_back #(
    .COORD_BITS (COORD_BITS),
    .job_t      (job_t)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (back_valid),
    .job_ready_o  (back_ready),
    .job_i        (back_job),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .status_o     (result_o.status),
    .twice_area_o (result_o.twice_area)
  );

endmodule

`default_nettype wire

// File: hdl/cpva_front.sv
// Front end: tracks polygon vertices and builds one arithmetic job per vertex.
`default_nettype none

module cpva_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter type         job_t      = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         is_last_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output job_t                         job_o
);
  import cpva_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  function automatic logic signed [CB:0] widen(logic signed [CB-1:0] a);
    return {a[CB-1], a};
  endfunction

  logic signed [CB-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic signed [CB-1:0] older_x_q, older_y_q, latest_x_q, latest_y_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic signed [CB-1:0] fst_x, fst_y;
  logic                 accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;

  // First vertex of the polygon closes onto itself
  assign fst_x = (count_q == '0) ? vertex_x_i : first_x_q;
  assign fst_y = (count_q == '0) ? vertex_y_i : first_y_q;

  always_comb begin
    job_o       = '0;
    job_o.count = count_q;
    job_o.last  = is_last_i;
    job_o.lat_x = latest_x_q;
    job_o.lat_y = latest_y_q;
    job_o.cur_x = vertex_x_i;
    job_o.cur_y = vertex_y_i;
    job_o.fst_x = fst_x;
    job_o.fst_y = fst_y;
    job_o.da1_x = widen(latest_x_q) - widen(older_x_q);
    job_o.da1_y = widen(latest_y_q) - widen(older_y_q);
    job_o.da2_x = widen(vertex_x_i) - widen(latest_x_q);
    job_o.da2_y = widen(vertex_y_i) - widen(latest_y_q);
    job_o.db2_x = widen(fst_x) - widen(vertex_x_i);
    job_o.db2_y = widen(fst_y) - widen(vertex_y_i);
    job_o.dc2_x = widen(second_x_q) - widen(first_x_q);
    job_o.dc2_y = widen(second_y_q) - widen(first_y_q);
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (is_last_i) begin
        count_d = '0;
      end else if (count_q != COUNT_MAX) begin
        count_d = count_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      first_x_q  <= '0;
      first_y_q  <= '0;
      second_x_q <= '0;
      second_y_q <= '0;
      older_x_q  <= '0;
      older_y_q  <= '0;
      latest_x_q <= '0;
      latest_y_q <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        if (count_q == '0) begin
          first_x_q <= vertex_x_i;
          first_y_q <= vertex_y_i;
        end
        if (count_q == COUNT_W'(1)) begin
          second_x_q <= vertex_x_i;
          second_y_q <= vertex_y_i;
        end
        older_x_q  <= latest_x_q;
        older_y_q  <= latest_y_q;
        latest_x_q <= vertex_x_i;
        latest_y_q <= vertex_y_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/cpva_job_fifo.sv
// Short job queue between the front end and the arithmetic back end.
`default_nettype none

module cpva_job_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/cpva_back.sv
// Back end: products, cross signs, shoelace accumulation and result register.
`default_nettype none

module cpva_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter type         job_t      = logic
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_valid_i,
  output logic                                 job_ready_o,
  input  job_t                                 job_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cpva_pkg::STATUS_W-1:0]        status_o,
  output logic [cpva_pkg::TWICE_AREA_W-1:0]    twice_area_o
);
  import cpva_pkg::*;

  localparam int unsigned PROD_W = 2 * COORD_BITS + 2;
  localparam int unsigned CR_W   = PROD_W + 1;
  localparam int unsigned EXT_W  = (CR_W > AREA_W) ? CR_W : AREA_W;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic                     last;
    logic signed [PROD_W-1:0] e1a, e1b, e2a, e2b;
    logic signed [PROD_W-1:0] taa, tab, tba, tbb, tca, tcb;
  } prod_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               last;
    logic [AREA_W-1:0]  e1, e2;
    logic               ta, tb, tc;
  } term_t;

  function automatic logic signed [CR_W-1:0] diff(logic signed [PROD_W-1:0] a,
                                                  logic signed [PROD_W-1:0] b);
    return CR_W'(a) - CR_W'(b);
  endfunction

  function automatic logic positive(logic signed [CR_W-1:0] d);
    return !d[CR_W-1] && (d != '0);
  endfunction

  function automatic logic [AREA_W-1:0] wrap(logic signed [CR_W-1:0] d);
    logic signed [EXT_W-1:0] t;
    t = EXT_W'(d);
    return t[AREA_W-1:0];
  endfunction

  logic               advance;
  logic               s1_valid_q, s2_valid_q, fin_valid_q, out_valid_q;
  prod_t              s1_q, s1_d;
  term_t              s2_q, s2_d;
  logic [AREA_W-1:0]  area_q, area_d;
  logic               turn_q, turn_d, convex_q, convex_d;
  logic [AREA_W-1:0]  fin_area_q;
  logic               fin_convex_q, fin_short_q;
  logic               turn_ref, ok_a, ok_wrap;
  logic [AREA_W-1:0]  mag;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [TWICE_AREA_W-1:0] twice_area_q, twice_area_d;

  // Whole back end moves only when the result slot can take a value
  assign advance     = !out_valid_q || out_ready_i;
  assign job_ready_o = advance;

  // Stage 1: one product per multiplier
  always_comb begin
    s1_d       = '0;
    s1_d.count = job_i.count;
    s1_d.last  = job_i.last;
    s1_d.e1a   = PROD_W'(job_i.lat_x) * PROD_W'(job_i.cur_y);
    s1_d.e1b   = PROD_W'(job_i.cur_x) * PROD_W'(job_i.lat_y);
    s1_d.e2a   = PROD_W'(job_i.cur_x) * PROD_W'(job_i.fst_y);
    s1_d.e2b   = PROD_W'(job_i.fst_x) * PROD_W'(job_i.cur_y);
    s1_d.taa   = PROD_W'(job_i.da1_x) * PROD_W'(job_i.da2_y);
    s1_d.tab   = PROD_W'(job_i.da1_y) * PROD_W'(job_i.da2_x);
    s1_d.tba   = PROD_W'(job_i.da2_x) * PROD_W'(job_i.db2_y);
    s1_d.tbb   = PROD_W'(job_i.da2_y) * PROD_W'(job_i.db2_x);
    s1_d.tca   = PROD_W'(job_i.db2_x) * PROD_W'(job_i.dc2_y);
    s1_d.tcb   = PROD_W'(job_i.db2_y) * PROD_W'(job_i.dc2_x);
  end

  // Stage 2: edge terms and turn signs; drop terms that do not apply
  always_comb begin
    s2_d       = '0;
    s2_d.count = s1_q.count;
    s2_d.last  = s1_q.last;
    s2_d.e1    = (s1_q.count != '0) ? wrap(diff(s1_q.e1a, s1_q.e1b)) : '0;
    s2_d.e2    = s1_q.last ? wrap(diff(s1_q.e2a, s1_q.e2b)) : '0;
    s2_d.ta    = positive(diff(s1_q.taa, s1_q.tab));
    s2_d.tb    = positive(diff(s1_q.tba, s1_q.tbb));
    s2_d.tc    = positive(diff(s1_q.tca, s1_q.tcb));
  end

  // Stage 3: accumulate area and convexity for the open polygon
  assign turn_ref = (s2_q.count == COUNT_W'(2)) ? s2_q.ta : turn_q;
  assign ok_a     = (s2_q.count != COUNT_MAX) || (s2_q.ta == turn_q);
  assign ok_wrap  = !(s2_q.last && (s2_q.count >= COUNT_W'(2))) ||
                    ((s2_q.tb == turn_ref) && (s2_q.tc == turn_ref));
  assign area_d   = area_q + s2_q.e1 + s2_q.e2;
  assign convex_d = convex_q && ok_a && ok_wrap;
  assign turn_d   = turn_ref;

  // Stage 4: magnitude, saturation and status
  assign mag          = fin_area_q[AREA_W-1] ? (~fin_area_q + AREA_W'(1)) : fin_area_q;
  assign twice_area_d = (|mag[AREA_W-1:TWICE_AREA_W]) ? {TWICE_AREA_W{1'b1}}
                                                      : mag[TWICE_AREA_W-1:0];
  always_comb begin
    if (fin_short_q) begin
      status_d = STATUS_SHORT;
    end else if (!fin_convex_q) begin
      status_d = STATUS_CONCAVE;
    end else if (fin_area_q == '0) begin
      status_d = STATUS_ZERO_AREA;
    end else begin
      status_d = STATUS_VALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      if (s2_valid_q && s2_q.last) begin
        fin_area_q   <= area_d;
        fin_convex_q <= convex_d;
        fin_short_q  <= (s2_q.count < COUNT_W'(2));
      end
      if (fin_valid_q) begin
        status_q     <= status_d;
        twice_area_q <= twice_area_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      turn_q      <= 1'b0;
      convex_q    <= 1'b1;
    end else if (advance) begin
      s1_valid_q  <= job_valid_i;
      s2_valid_q  <= s1_valid_q;
      fin_valid_q <= s2_valid_q && s2_q.last;
      out_valid_q <= fin_valid_q;
      if (s2_valid_q) begin
        if (s2_q.last) begin
          area_q   <= '0;
          turn_q   <= 1'b0;
          convex_q <= 1'b1;
        end else begin
          area_q   <= area_d;
          turn_q   <= turn_d;
          convex_q <= convex_d;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign twice_area_o = twice_area_q;

endmodule

`default_nettype wire

// File: hdl/cpva_checker.sv
// Port-level assertions for the block, bound to the top level.
`default_nettype none

module cpva_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [cpva_pkg::STATUS_W-1:0]       status_i,
  input  logic [cpva_pkg::TWICE_AREA_W-1:0]   twice_area_i
);
  import cpva_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
                                    $stable(twice_area_i))
    else $error("result changed while stalled");

  // One or two vertices enclose no area
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_SHORT) |-> twice_area_i == '0)
    else $error("short polygon reports nonzero area");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_ZERO_AREA) |-> twice_area_i == '0)
    else $error("zero-area status with nonzero area");

  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_VALID) |-> twice_area_i != '0)
    else $error("valid status with zero area");

endmodule

bind convex_polygon_validate_area cpva_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .status_i     (result_o.status),
  .twice_area_i (result_o.twice_area)
);

`default_nettype wire
